// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the boost floor controller checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define IBFC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ibfc assertion failed");

// Next-cycle implication, disabled while rst is high.
`define IBFC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ibfc assertion failed");

`endif

// ===== design/ibfc_pkg.sv =====
// ----------------------------------------------------------------------------
// ibfc_pkg
// Types and constants of the input boost frequency floor controller.
// ----------------------------------------------------------------------------
package ibfc_pkg;

   localparam int FREQ_W         = 22;
   localparam int DUR_W          = 16;
   localparam int OP_W           = 3;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 22;

   typedef enum logic [OP_W-1:0] {
      OP_TICK       = 3'd0,
      OP_INPUT      = 3'd1,
      OP_KICK       = 3'd2,
      OP_SCREEN_ON  = 3'd3,
      OP_SCREEN_OFF = 3'd4,
      OP_QUERY      = 3'd5
   } op_type;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOOST_FREQ_LP     = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOOST_FREQ_PERF   = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_FREQ_LP       = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_FREQ_PERF     = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLOOR_FREQ_LP     = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLOOR_FREQ_PERF   = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INPUT_BOOST_TICKS = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAKE_BOOST_TICKS  = 4'd7;

   // register reset values
   localparam logic [FREQ_W-1:0] RST_BOOST_FREQ     = 22'd1000000;
   localparam logic [FREQ_W-1:0] RST_MAX_FREQ       = 22'd4194303;
   localparam logic [FREQ_W-1:0] RST_FLOOR_FREQ     = 22'd0;
   localparam logic [DUR_W-1:0]  RST_INPUT_TICKS    = 16'd64;
   localparam logic [DUR_W-1:0]  RST_WAKE_TICKS     = 16'd1000;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DUR_W-1:0]  kick_ticks;
      logic              cluster_is_lp;
      logic [FREQ_W-1:0] policy_max_khz;
      logic [FREQ_W-1:0] hw_min_khz;
   } req_type;

   typedef struct packed {
      logic [FREQ_W-1:0] min_freq_khz;
      logic              screen_is_off;
      logic              input_boost_on;
      logic              max_boost_on;
      logic              flags_changed;
   } rsp_type;

   typedef struct packed {
      logic [FREQ_W-1:0] boost_freq_lp;
      logic [FREQ_W-1:0] boost_freq_perf;
      logic [FREQ_W-1:0] max_freq_lp;
      logic [FREQ_W-1:0] max_freq_perf;
      logic [FREQ_W-1:0] floor_freq_lp;
      logic [FREQ_W-1:0] floor_freq_perf;
      logic [DUR_W-1:0]  input_boost_ticks;
      logic [DUR_W-1:0]  wake_boost_ticks;
   } cfg_type;

endpackage

// ===== design/ibfc_regs.sv =====
// ----------------------------------------------------------------------------
// ibfc_regs
// Configuration register file; writes beyond the last index are dropped.
// ----------------------------------------------------------------------------
module ibfc_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [ibfc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ibfc_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output ibfc_pkg::cfg_type                   cfg
);
   import ibfc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BOOST_FREQ_LP:     cfg_in.boost_freq_lp     = csr_data[FREQ_W-1:0];
            CSR_BOOST_FREQ_PERF:   cfg_in.boost_freq_perf   = csr_data[FREQ_W-1:0];
            CSR_MAX_FREQ_LP:       cfg_in.max_freq_lp       = csr_data[FREQ_W-1:0];
            CSR_MAX_FREQ_PERF:     cfg_in.max_freq_perf     = csr_data[FREQ_W-1:0];
            CSR_FLOOR_FREQ_LP:     cfg_in.floor_freq_lp     = csr_data[FREQ_W-1:0];
            CSR_FLOOR_FREQ_PERF:   cfg_in.floor_freq_perf   = csr_data[FREQ_W-1:0];
            CSR_INPUT_BOOST_TICKS: cfg_in.input_boost_ticks = csr_data[DUR_W-1:0];
            CSR_WAKE_BOOST_TICKS:  cfg_in.wake_boost_ticks  = csr_data[DUR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.boost_freq_lp     <= RST_BOOST_FREQ;
         cfg_ff.boost_freq_perf   <= RST_BOOST_FREQ;
         cfg_ff.max_freq_lp       <= RST_MAX_FREQ;
         cfg_ff.max_freq_perf     <= RST_MAX_FREQ;
         cfg_ff.floor_freq_lp     <= RST_FLOOR_FREQ;
         cfg_ff.floor_freq_perf   <= RST_FLOOR_FREQ;
         cfg_ff.input_boost_ticks <= RST_INPUT_TICKS;
         cfg_ff.wake_boost_ticks  <= RST_WAKE_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/input_boost_freq_floor_ctrl.sv =====
// ----------------------------------------------------------------------------
// input_boost_freq_floor_ctrl
// Event driven CPU frequency floor controller with input and max boost timers.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/ready) carries one request: tick, input event, max
//    kick, screen on, screen off or query. Every request gives one response.
//  - rsp channel (valid/ready) returns the query floor (zero for non-query
//    requests) and the screen/boost flags after the request.
//  - csr channel writes one of eight registers per cycle; csr_ready is always
//    high. Write only while no request is in flight.
//  - Path: a request passes the input register, then the response register;
//    a response stall can hold it in the input register.
//  - Throughput: one request per cycle while rsp_ready stays high. The
//    timer/flag update is a single pass of compares and muxes between the
//    input register and the response register.
//  - Stall: while rsp_ready is low the response register holds; the input
//    register still takes one more request, then req_ready drops.
//  - Reset (synchronous): timers zero, screen on, registers to defaults,
//    both pipeline stages empty.
// ----------------------------------------------------------------------------
module input_boost_freq_floor_ctrl #(
   parameter int TIMER_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ibfc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ibfc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ibfc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ibfc_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import ibfc_pkg::*;

   // durations arrive 16 bits wide; compare in the wider of the two widths
   localparam int WIDE_W = (TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W;
   localparam logic [WIDE_W-1:0] TMAX_WIDE = WIDE_W'({TIMER_BITS{1'b1}});

   function automatic logic [TIMER_BITS-1:0] sat_ticks(input logic [DUR_W-1:0] v);
      logic [WIDE_W-1:0] ext;
      ext = WIDE_W'(v);
      if (ext > TMAX_WIDE) begin
         return TIMER_BITS'(TMAX_WIDE);
      end
      return TIMER_BITS'(ext);
   endfunction

   cfg_type cfg;

   // pipeline control
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_req_ff, s1_req_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    advance;
   logic    fire;

   // controller state
   logic                  screen_off_ff, screen_off_in;
   logic [TIMER_BITS-1:0] input_left_ff, input_left_in;
   logic [TIMER_BITS-1:0] max_left_ff, max_left_in;

   // compute helpers
   logic [TIMER_BITS-1:0] kick_t, wake_t, input_t;
   logic [FREQ_W-1:0]     boost_sel, max_sel, floor_sel, freq;
   logic                  lp;

   ibfc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign csr_ready = 1'b1;

   // response register empties or drains -> whole pipe moves
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign fire      = advance && s1_valid_ff;

   assign s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
   assign s1_req_in    = (req_valid && req_ready) ? req_data : s1_req_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   assign kick_t  = sat_ticks(s1_req_ff.kick_ticks);
   assign wake_t  = sat_ticks(cfg.wake_boost_ticks);
   assign input_t = sat_ticks(cfg.input_boost_ticks);

   assign lp        = s1_req_ff.cluster_is_lp;
   assign boost_sel = lp ? cfg.boost_freq_lp : cfg.boost_freq_perf;
   assign max_sel   = lp ? cfg.max_freq_lp   : cfg.max_freq_perf;
   assign floor_sel = lp ? cfg.floor_freq_lp : cfg.floor_freq_perf;

   always_comb begin
      screen_off_in = screen_off_ff;
      input_left_in = input_left_ff;
      max_left_in   = max_left_ff;
      freq          = '0;
      if (fire) begin
         case (op_type'(s1_req_ff.op))
            OP_TICK: begin
               // timers run with the screen off too
               if (|input_left_ff) input_left_in = input_left_ff - TIMER_BITS'(1);
               if (|max_left_ff)   max_left_in   = max_left_ff - TIMER_BITS'(1);
            end
            OP_INPUT: begin
               if (!screen_off_ff) input_left_in = input_t;
            end
            OP_KICK: begin
               // a strictly longer running boost is kept
               if (!screen_off_ff && !(max_left_ff > kick_t)) max_left_in = kick_t;
            end
            OP_SCREEN_ON: begin
               screen_off_in = 1'b0;
               if (!(max_left_ff > wake_t)) max_left_in = wake_t;
            end
            OP_SCREEN_OFF: begin
               screen_off_in = 1'b1;
            end
            OP_QUERY: begin
               if (screen_off_ff) begin
                  freq = s1_req_ff.hw_min_khz;
               end else if (|max_left_ff) begin
                  freq = (max_sel < s1_req_ff.policy_max_khz) ?
                         max_sel : s1_req_ff.policy_max_khz;
               end else if (|input_left_ff) begin
                  freq = (boost_sel < s1_req_ff.policy_max_khz) ?
                         boost_sel : s1_req_ff.policy_max_khz;
               end else begin
                  // idle floor is not clamped by the policy max
                  freq = (s1_req_ff.hw_min_khz > floor_sel) ?
                         s1_req_ff.hw_min_khz : floor_sel;
               end
            end
            default: ;  // unused op codes change nothing
         endcase
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (fire) begin
         rsp_data_in.min_freq_khz   = freq;
         rsp_data_in.screen_is_off  = screen_off_in;
         rsp_data_in.input_boost_on = |input_left_in;
         rsp_data_in.max_boost_on   = |max_left_in;
         rsp_data_in.flags_changed  = (screen_off_in != screen_off_ff)
                                   || ((|input_left_in) != (|input_left_ff))
                                   || ((|max_left_in) != (|max_left_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         screen_off_ff <= 1'b0;
         input_left_ff <= '0;
         max_left_ff   <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         screen_off_ff <= screen_off_in;
         input_left_ff <= input_left_in;
         max_left_ff   <= max_left_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_req_ff   <= s1_req_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/ibfc_checker.sv =====
// ----------------------------------------------------------------------------
// ibfc_checker
// Port-level checks of the boost floor controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ibfc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ibfc_pkg::rsp_type rsp_data
);
   import ibfc_pkg::*;

   logic rsp_stall;
   logic rsp_take;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign rsp_take   = rsp_valid && rsp_ready;

   // stalled response holds
   `IBFC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // pipe comes out of reset empty
   `IBFC_ASSERT_NXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid)

   // empty response stage never back-pressures requests
   `IBFC_ASSERT_IMP(a_ready_empty, clock, reset, !rsp_valid, req_ready)

   // back-to-back responses: no flag change reported means flags equal
   `IBFC_ASSERT_IMP(a_flags_chain, clock, reset,
      $past(rsp_take) && rsp_valid && !rsp_data.flags_changed,
      (rsp_data.screen_is_off == $past(rsp_data.screen_is_off))
      && (rsp_data.input_boost_on == $past(rsp_data.input_boost_on))
      && (rsp_data.max_boost_on == $past(rsp_data.max_boost_on)))

endmodule

bind input_boost_freq_floor_ctrl ibfc_checker u_ibfc_checker (.*);

// ===== tb/sv/tb_input_boost_freq_floor_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_input_boost_freq_floor_ctrl
// Self-checking bench for the boost frequency floor controller. An in-bench
// mirror of the timers, the screen flag and the registers predicts one
// response per request. Responses are compared field by field, in order.
// Stimulus: directed corner cases, register extremes, a long response stall,
// random phases, random settings and handshake gaps, one gapless, a long kick.
// ----------------------------------------------------------------------------
module tb_input_boost_freq_floor_ctrl;
   import ibfc_pkg::*;

   localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
   localparam logic [DUR_W-1:0]  DUR_MAX  = '1;

   // op codes the block leaves unused
   localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

   // register indexes with no register behind them
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_LO = 4'd8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_HI = 4'd15;

   localparam int HOLD_CYCLES    = 40;    // long response stall
   localparam int DRAIN_TAIL     = 4;     // two pipeline stages plus margin
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
   localparam int MAX_PRINTS     = 40;

   // DUT inputs start at known values
   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   // mirror of the block's state and registers
   cfg_type          cfg_mirror;
   logic             screen_off_m;
   logic [DUR_W-1:0] input_left_m;
   logic [DUR_W-1:0] max_left_m;

   // predicted responses, oldest first
   rsp_type     floor_flag_q[$];

   int unsigned err_count    = 0;
   int unsigned rsp_count    = 0;
   int unsigned stuck_cycles = 0;
   bit          idle_on      = 1'b1;  // random gaps on both channels
   bit          hold_rsp     = 1'b0;  // request for one long response stall

   input_boost_freq_floor_ctrl dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // max kick: ignored with screen off; a strictly longer running boost wins
   function automatic void kick_max(input logic [DUR_W-1:0] len);
      if (!screen_off_m && max_left_m <= len)
         max_left_m = len;
   endfunction

   // applies one request to the mirror, returns the response it gives
   function automatic rsp_type step_boost(input req_type r);
      rsp_type           o;
      logic              was_off;
      logic              was_input;
      logic              was_max;
      logic [FREQ_W-1:0] boost;
      logic [FREQ_W-1:0] floor_f;
      was_off   = screen_off_m;
      was_input = (input_left_m != '0);
      was_max   = (max_left_m != '0);
      o = '0;
      case (r.op)
         OP_TICK: begin
            // timers run on with the screen off too
            if (input_left_m != '0) input_left_m = input_left_m - DUR_W'(1);
            if (max_left_m != '0)   max_left_m   = max_left_m - DUR_W'(1);
         end
         OP_INPUT: begin
            if (!screen_off_m) input_left_m = cfg_mirror.input_boost_ticks;
         end
         OP_KICK: kick_max(r.kick_ticks);
         OP_SCREEN_ON: begin
            screen_off_m = 1'b0;
            kick_max(cfg_mirror.wake_boost_ticks);
         end
         OP_SCREEN_OFF: screen_off_m = 1'b1;
         OP_QUERY: begin
            if (screen_off_m) begin
               o.min_freq_khz = r.hw_min_khz;
            end else if (max_left_m != '0 || input_left_m != '0) begin
               if (max_left_m != '0)
                  boost = r.cluster_is_lp ? cfg_mirror.max_freq_lp : cfg_mirror.max_freq_perf;
               else
                  boost = r.cluster_is_lp ? cfg_mirror.boost_freq_lp
                                          : cfg_mirror.boost_freq_perf;
               o.min_freq_khz = (boost < r.policy_max_khz) ? boost : r.policy_max_khz;
            end else begin
               // idle floor, not clamped by the policy max
               floor_f = r.cluster_is_lp ? cfg_mirror.floor_freq_lp : cfg_mirror.floor_freq_perf;
               o.min_freq_khz = (r.hw_min_khz > floor_f) ? r.hw_min_khz : floor_f;
            end
         end
         default: ;  // unused op codes change nothing
      endcase
      o.screen_is_off  = screen_off_m;
      o.input_boost_on = (input_left_m != '0);
      o.max_boost_on   = (max_left_m != '0);
      o.flags_changed  = (was_off != o.screen_is_off) || (was_input != o.input_boost_on) ||
                         (was_max != o.max_boost_on);
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (err_count < MAX_PRINTS)
         $display("[%0t] response %0d: %s got 0x%0h, want 0x%0h",
                  $time, rsp_count, field, got, want);
      err_count++;
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BOOST_FREQ_LP:     cfg_mirror.boost_freq_lp     = d;
         CSR_BOOST_FREQ_PERF:   cfg_mirror.boost_freq_perf   = d;
         CSR_MAX_FREQ_LP:       cfg_mirror.max_freq_lp       = d;
         CSR_MAX_FREQ_PERF:     cfg_mirror.max_freq_perf     = d;
         CSR_FLOOR_FREQ_LP:     cfg_mirror.floor_freq_lp     = d;
         CSR_FLOOR_FREQ_PERF:   cfg_mirror.floor_freq_perf   = d;
         CSR_INPUT_BOOST_TICKS: cfg_mirror.input_boost_ticks = d[DUR_W-1:0];
         CSR_WAKE_BOOST_TICKS:  cfg_mirror.wake_boost_ticks  = d[DUR_W-1:0];
         default: ;  // unmapped index: write dropped
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_cfg(input cfg_type c);
      csr_write(CSR_BOOST_FREQ_LP,     c.boost_freq_lp);
      csr_write(CSR_BOOST_FREQ_PERF,   c.boost_freq_perf);
      csr_write(CSR_MAX_FREQ_LP,       c.max_freq_lp);
      csr_write(CSR_MAX_FREQ_PERF,     c.max_freq_perf);
      csr_write(CSR_FLOOR_FREQ_LP,     c.floor_freq_lp);
      csr_write(CSR_FLOOR_FREQ_PERF,   c.floor_freq_perf);
      csr_write(CSR_INPUT_BOOST_TICKS, CSR_DATA_BITS'(c.input_boost_ticks));
      csr_write(CSR_WAKE_BOOST_TICKS,  CSR_DATA_BITS'(c.wake_boost_ticks));
   endtask

   // valid stays high from one request to the next unless a gap is drawn
   task automatic send_req(input req_type r);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      floor_flag_q.push_back(step_boost(r));
   endtask

   // sender pauses until every predicted response is back
   task automatic drain_floors();
      req_valid <= 1'b0;
      while (floor_flag_q.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   function automatic req_type mk_req(input logic [OP_W-1:0] op, input logic [DUR_W-1:0] kick,
                                      input logic lp, input logic [FREQ_W-1:0] pmax,
                                      input logic [FREQ_W-1:0] hwmin);
      req_type r;
      r.op             = op;
      r.kick_ticks     = kick;
      r.cluster_is_lp  = lp;
      r.policy_max_khz = pmax;
      r.hw_min_khz     = hwmin;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Random values
   // ------------------------------------------------------------------------

   function automatic logic [FREQ_W-1:0] pick_freq();
      logic [FREQ_W-1:0] v;
      case ($urandom_range(0, 7))
         0:       v = '0;
         1:       v = FREQ_MAX;
         default: v = FREQ_W'($urandom);
      endcase
      return v;
   endfunction

   // mostly short so boosts expire inside a phase
   function automatic logic [DUR_W-1:0] pick_ticks();
      logic [DUR_W-1:0] v;
      if ($urandom_range(0, 15) == 0) v = DUR_W'($urandom_range(16, 300));
      else                            v = DUR_W'($urandom_range(0, 8));
      return v;
   endfunction

   function automatic req_type rand_req();
      req_type     r;
      int unsigned roll;
      r.kick_ticks     = DUR_W'($urandom);  // full range on ops that ignore it
      r.cluster_is_lp  = 1'($urandom_range(0, 1));
      r.policy_max_khz = pick_freq();
      r.hw_min_khz     = pick_freq();
      roll = $urandom_range(0, 99);
      if (roll < 35)      r.op = OP_TICK;
      else if (roll < 45) r.op = OP_INPUT;
      else if (roll < 55) r.op = OP_KICK;
      else if (roll < 60) r.op = OP_SCREEN_ON;
      else if (roll < 64) r.op = OP_SCREEN_OFF;
      else if (roll < 97) r.op = OP_QUERY;
      else                r.op = ($urandom_range(0, 1) == 1) ? OP_UNUSED_A : OP_UNUSED_B;
      // real kicks stay short, else the max boost would mask everything else
      if (r.op == OP_KICK)
         r.kick_ticks = ($urandom_range(0, 49) == 0) ? DUR_W'($urandom_range(0, 400))
                                                      : DUR_W'($urandom_range(0, 12));
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   task automatic test_directed();
      // reset settings, no boost: idle floor, policy max does not clamp it
      send_req(mk_req(OP_QUERY, '0, 1'b1, FREQ_MAX, '0));
      send_req(mk_req(OP_QUERY, DUR_MAX, 1'b0, '0, FREQ_MAX));
      send_req(mk_req(OP_UNUSED_A, DUR_MAX, 1'b1, FREQ_MAX, FREQ_MAX));
      send_req(mk_req(OP_UNUSED_B, '0, 1'b0, '0, '0));
      send_req(mk_req(OP_INPUT, '0, 1'b0, '0, '0));
      send_req(mk_req(OP_QUERY, '0, 1'b1, FREQ_MAX, '0));
      send_req(mk_req(OP_QUERY, '0, 1'b0, '0, FREQ_MAX));
      // short boosts from here on
      drain_floors();
      csr_write(CSR_INPUT_BOOST_TICKS, 22'd2);
      csr_write(CSR_WAKE_BOOST_TICKS, 22'd3);
      send_req(mk_req(OP_INPUT, '0, 1'b0, '0, '0));  // reload, not a max
      send_req(mk_req(OP_TICK, '0, 1'b0, '0, '0));
      send_req(mk_req(OP_TICK, '0, 1'b0, '0, '0));   // input boost ends
      send_req(mk_req(OP_TICK, '0, 1'b0, '0, '0));   // timers hold at zero
      send_req(mk_req(OP_QUERY, '0, 1'b1, FREQ_MAX, 22'd1234));
      send_req(mk_req(OP_KICK, '0, 1'b0, '0, '0));   // zero-length kick
      send_req(mk_req(OP_KICK, 16'd4, 1'b0, '0, '0));
      send_req(mk_req(OP_KICK, 16'd2, 1'b0, '0, '0)); // longer boost kept
      send_req(mk_req(OP_KICK, 16'd4, 1'b0, '0, '0)); // equal length reloads
      send_req(mk_req(OP_QUERY, '0, 1'b1, FREQ_MAX, '0));
      send_req(mk_req(OP_QUERY, '0, 1'b0, 22'd777, FREQ_MAX));
      // screen off: events and kicks dropped, ticks still count
      send_req(mk_req(OP_SCREEN_OFF, '0, 1'b0, '0, '0));
      send_req(mk_req(OP_INPUT, '0, 1'b0, '0, '0));
      send_req(mk_req(OP_KICK, DUR_MAX, 1'b0, '0, '0));
      send_req(mk_req(OP_TICK, '0, 1'b0, '0, '0));
      send_req(mk_req(OP_QUERY, '0, 1'b1, '0, FREQ_MAX));
      send_req(mk_req(OP_SCREEN_ON, '0, 1'b0, '0, '0)); // wake kick
      send_req(mk_req(OP_QUERY, '0, 1'b0, FREQ_MAX, '0));
   endtask

   task automatic test_register_extremes();
      cfg_type c;
      // let the wake boost run out
      repeat (4) send_req(mk_req(OP_TICK, '0, 1'b0, '0, '0));
      drain_floors();
      c = '1;
      program_cfg(c);
      csr_write(CSR_INPUT_BOOST_TICKS, FREQ_MAX);  // upper data bits dropped
      send_req(mk_req(OP_INPUT, '0, 1'b0, '0, '0));
      send_req(mk_req(OP_QUERY, '0, 1'b1, FREQ_MAX, '0));
      send_req(mk_req(OP_QUERY, '0, 1'b0, 22'd12345, '0));
      drain_floors();
      csr_write(CSR_INPUT_BOOST_TICKS, '0);
      send_req(mk_req(OP_INPUT, '0, 1'b0, '0, '0));  // zero-length reload
      send_req(mk_req(OP_QUERY, '0, 1'b0, '0, '0));
      send_req(mk_req(OP_QUERY, '0, 1'b1, FREQ_MAX, FREQ_MAX));
      drain_floors();
      c = '0;
      program_cfg(c);
      send_req(mk_req(OP_SCREEN_OFF, '0, 1'b0, '0, '0));
      send_req(mk_req(OP_SCREEN_ON, '0, 1'b0, '0, '0));  // zero wake boost
      send_req(mk_req(OP_QUERY, '0, 1'b1, FREQ_MAX, 22'h2AAAAA));
      send_req(mk_req(OP_KICK, 16'd1, 1'b0, '0, '0));
      send_req(mk_req(OP_QUERY, '0, 1'b0, FREQ_MAX, FREQ_MAX));
      send_req(mk_req(OP_TICK, '0, 1'b0, '0, '0));
      drain_floors();
      // unmapped indexes must not alias onto real registers
      csr_write(CSR_UNMAPPED_LO, FREQ_MAX);
      csr_write(CSR_UNMAPPED_HI, FREQ_MAX);
      send_req(mk_req(OP_INPUT, '0, 1'b0, '0, '0));
      send_req(mk_req(OP_QUERY, '0, 1'b1, FREQ_MAX, '0));
      send_req(mk_req(OP_QUERY, '0, 1'b0, FREQ_MAX, '0));
   endtask

   task automatic test_random_phase(input int unsigned n);
      cfg_type c;
      drain_floors();
      c.boost_freq_lp     = pick_freq();
      c.boost_freq_perf   = pick_freq();
      c.max_freq_lp       = pick_freq();
      c.max_freq_perf     = pick_freq();
      c.floor_freq_lp     = pick_freq();
      c.floor_freq_perf   = pick_freq();
      c.input_boost_ticks = pick_ticks();
      c.wake_boost_ticks  = pick_ticks();
      program_cfg(c);
      csr_write(CSR_INDEX_BITS'($urandom_range(CSR_UNMAPPED_LO, CSR_UNMAPPED_HI)),
                CSR_DATA_BITS'($urandom));
      repeat (n) send_req(rand_req());
   endtask

   // receiver holds off while the sender keeps offering: input side stalls
   task automatic test_rsp_backpressure();
      drain_floors();
      hold_rsp = 1'b1;
      repeat (24) send_req(rand_req());
      drain_floors();
   endtask

   // full-length kick last, so it masks nothing that follows
   task automatic test_long_boost();
      send_req(mk_req(OP_SCREEN_ON, '0, 1'b0, '0, '0));
      send_req(mk_req(OP_KICK, DUR_MAX, 1'b0, '0, '0));
      send_req(mk_req(OP_KICK, 16'd5, 1'b1, '0, '0));
      send_req(mk_req(OP_QUERY, '0, 1'b1, FREQ_MAX, '0));
      send_req(mk_req(OP_SCREEN_ON, '0, 1'b0, '0, '0));
      send_req(mk_req(OP_TICK, '0, 1'b0, '0, '0));
      send_req(mk_req(OP_QUERY, '0, 1'b0, 22'd999, FREQ_MAX));
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   // short random stalls, or one long hold when asked
   initial begin : rsp_ready_drive
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (hold_rsp) begin
            hold_rsp   = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (floor_flag_q.size() == 0) begin
            report_mismatch("response with none pending", 32'(rsp_data), '0);
         end else begin
            want = floor_flag_q.pop_front();
            if (rsp_data.min_freq_khz !== want.min_freq_khz)
               report_mismatch("min_freq_khz", 32'(rsp_data.min_freq_khz),
                               32'(want.min_freq_khz));
            if (rsp_data.screen_is_off !== want.screen_is_off)
               report_mismatch("screen_is_off", 32'(rsp_data.screen_is_off),
                               32'(want.screen_is_off));
            if (rsp_data.input_boost_on !== want.input_boost_on)
               report_mismatch("input_boost_on", 32'(rsp_data.input_boost_on),
                               32'(want.input_boost_on));
            if (rsp_data.max_boost_on !== want.max_boost_on)
               report_mismatch("max_boost_on", 32'(rsp_data.max_boost_on),
                               32'(want.max_boost_on));
            if (rsp_data.flags_changed !== want.flags_changed)
               report_mismatch("flags_changed", 32'(rsp_data.flags_changed),
                               32'(want.flags_changed));
         end
      end
   end

   // ends a hung run: no handshake on any channel for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------

   initial begin : test_sequence
      cfg_mirror = '{boost_freq_lp:     RST_BOOST_FREQ,
                     boost_freq_perf:   RST_BOOST_FREQ,
                     max_freq_lp:       RST_MAX_FREQ,
                     max_freq_perf:     RST_MAX_FREQ,
                     floor_freq_lp:     RST_FLOOR_FREQ,
                     floor_freq_perf:   RST_FLOOR_FREQ,
                     input_boost_ticks: RST_INPUT_TICKS,
                     wake_boost_ticks:  RST_WAKE_TICKS};
      screen_off_m = 1'b0;
      input_left_m = '0;
      max_left_m   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_extremes();
      test_rsp_backpressure();
      repeat (4) test_random_phase(90);
      idle_on = 1'b0;  // closing stretch at full rate
      test_random_phase(50);
      test_long_boost();
      drain_floors();

      if (err_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== input_boost_freq_floor_ctrl.f =====
+incdir+design
design/ibfc_pkg.sv
design/ibfc_regs.sv
design/input_boost_freq_floor_ctrl.sv
design/ibfc_checker.sv
tb/sv/tb_input_boost_freq_floor_ctrl.sv
